// ----- rtl/power_meter_packet_parser_defines.svh -----
// ----------------------------------------------------------------------------
// Power meter packet parser: assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef POWER_METER_PACKET_PARSER_DEFINES_SVH
`define POWER_METER_PACKET_PARSER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PMP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pmp_pkg.sv -----
// ----------------------------------------------------------------------------
// Power meter packet parser package
// Constants, verdict codes and the token closing function.
// ----------------------------------------------------------------------------
package pmp_pkg;

  localparam int unsigned PMP_FIELD_COUNT = 18;
  localparam int unsigned PMP_VALUE_BITS  = 16;
  localparam int unsigned OUT_W           = 16;
  localparam int unsigned VERDICT_W       = 3;

  localparam logic [7:0] CHR_HASH  = 8'h23;
  localparam logic [7:0] CHR_SEMI  = 8'h3B;
  localparam logic [7:0] CHR_COMMA = 8'h2C;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_CMD_D = 8'h64;

  localparam logic [4:0] TOK_CMD   = 5'd0;
  localparam logic [4:0] TOK_SUB   = 5'd1;
  localparam logic [4:0] TOK_LEN   = 5'd2;
  localparam logic [4:0] TOK_WATTS = 5'd3;
  localparam logic [4:0] TOK_VOLTS = 5'd4;
  localparam logic [4:0] TOK_MAX   = 5'd31;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_OK         = 3'd0,
    VERDICT_NO_START   = 3'd1,
    VERDICT_FEW_TOKENS = 3'd2,
    VERDICT_BAD_CMD    = 3'd3,
    VERDICT_BAD_SUB    = 3'd4,
    VERDICT_NO_LENGTH  = 3'd5,
    VERDICT_MISMATCH   = 3'd6,
    VERDICT_OTHER      = 3'd7
  } verdict_e;

  typedef struct packed {
    logic             cmd_ok;
    logic             sub_ok;
    logic             len_present;
    logic [OUT_W-1:0] declared;
    logic [OUT_W-1:0] watts;
    logic [OUT_W-1:0] volts;
  } pmp_tok_t;

  // Records what the token that has just ended contributes to the checks.
  function automatic pmp_tok_t close_token(pmp_tok_t t, logic [4:0] tn, logic [2:0] tc,
                                           logic neg, logic [OUT_W-1:0] clamped,
                                           logic nz);
    pmp_tok_t r;
    r = t;
    unique case (tn)
      TOK_CMD:   r.cmd_ok = (tc == 3'd2);
      TOK_SUB:   r.sub_ok = (tc == 3'd1);
      TOK_LEN: begin
        r.len_present = (tc != 3'd0);
        r.declared    = (neg && nz) ? '1 : clamped;
      end
      TOK_WATTS: r.watts = neg ? '0 : clamped;
      TOK_VOLTS: r.volts = neg ? '0 : clamped;
      default: r = t;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/pmp_ifs.sv -----
// ----------------------------------------------------------------------------
// Power meter packet parser channels
// Valid/ready channels for received bytes and for chunk results.
// ----------------------------------------------------------------------------
interface pmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       chunk_end;

  modport source (output valid, output rx_byte, output chunk_end, input ready);
  modport sink (input valid, input rx_byte, input chunk_end, output ready);
endinterface

interface pmp_result_if
  import pmp_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 reading_valid;
  logic [VERDICT_W-1:0] verdict;
  logic [OUT_W-1:0]     watts_tenths;
  logic [OUT_W-1:0]     volts_tenths;

  modport source (output valid, output reading_valid, output verdict,
                  output watts_tenths, output volts_tenths, input ready);
  modport sink (input valid, input reading_valid, input verdict,
                input watts_tenths, input volts_tenths, output ready);
endinterface

// ----- rtl/power_meter_packet_parser.sv -----
// ----------------------------------------------------------------------------
// Power meter packet parser
// Parses the bytes of one serial read chunk and reports one verdict per chunk.
// ----------------------------------------------------------------------------
// Usage:
// Bytes of a read chunk enter on rx_i, one item per accepted byte, with
// chunk_end set on the last byte. Every byte updates the parser state in the
// cycle in which it is accepted, so while rx_i.ready is high one byte can be
// taken in every clock cycle. Only the byte carrying chunk_end yields a result
// item on res_o, holding the verdict and, for a complete reading packet, the
// watts and volts in tenths. The result is registered, and the parser is
// clear for the next chunk as soon as the chunk_end byte is accepted.
// A result register and a skid register stand in front of res_o, so bytes keep
// flowing while a result waits; rx_i.ready falls only when both hold a result,
// and rises again in the cycle after res_o takes one.
// Reset clears the parser state and the valid flags of both result registers;
// no result is lost or repeated however long the receiver stalls.
// ----------------------------------------------------------------------------
module power_meter_packet_parser
  import pmp_pkg::*;
#(
  parameter int unsigned FIELD_COUNT = PMP_FIELD_COUNT,
  parameter int unsigned VALUE_BITS  = PMP_VALUE_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pmp_byte_if.sink             rx_i,
  pmp_result_if.source         res_o
);

`include "power_meter_packet_parser_defines.svh"

  localparam int unsigned VB = VALUE_BITS;
  localparam logic [4:0] FieldCountW = 5'(FIELD_COUNT);
  localparam logic [OUT_W-1:0] OutMax = '1;

  typedef struct packed {
    logic                 reading_valid;
    verdict_e             verdict;
    logic [OUT_W-1:0]     watts;
    logic [OUT_W-1:0]     volts;
  } pmp_res_t;

  logic            capturing_q, capturing_d;
  logic            closed_q, closed_d;
  logic            text_ended_q, text_ended_d;
  logic [1:0]      chunk_count_q, chunk_count_d;
  logic [4:0]      token_number_q, token_number_d;
  logic [2:0]      token_chars_q, token_chars_d;
  logic [2:0]      pend_ws_q, pend_ws_d;
  logic [7:0]      command_char_q, command_char_d;
  logic [7:0]      subcommand_char_q, subcommand_char_d;
  logic [VB-1:0]   number_accum_q, number_accum_d;
  logic            number_done_q, number_done_d;
  logic            number_neg_q, number_neg_d;
  pmp_tok_t        tok_q, tok_d;

  logic            out_valid_q, out_valid_d;
  logic            skid_valid_q, skid_valid_d;
  pmp_res_t        out_q, out_d;
  pmp_res_t        skid_q, skid_d;
  pmp_res_t        res_new;
  logic            accept;
  logic            res_push;
  logic            out_pop;

  function automatic logic [OUT_W-1:0] sat_out(logic [VB-1:0] a);
    logic [VB+OUT_W-1:0] w;
    w = {{OUT_W{1'b0}}, a};
    return (w > (VB+OUT_W)'(OutMax)) ? OutMax : w[OUT_W-1:0];
  endfunction

  assign accept    = rx_i.valid && rx_i.ready;
  assign res_push  = accept && rx_i.chunk_end;
  assign out_pop   = out_valid_q && res_o.ready;
  assign rx_i.ready = !skid_valid_q;

  always_comb begin
    logic [7:0]    c;
    logic          ws;
    logic [3:0]    pos;
    logic [VB+3:0] acc_x;
    pmp_tok_t      tok_end;
    logic [4:0]    tn_less;
    c        = rx_i.rx_byte;
    ws       = (c == CHR_SPACE) || (c >= CHR_TAB && c <= CHR_CR);
    pos      = 4'(token_chars_q) + 4'(pend_ws_q);
    acc_x    = ({4'b0, number_accum_q} << 3) + ({4'b0, number_accum_q} << 1)
               + (VB+4)'(c[3:0]);
    tok_end  = tok_q;
    tn_less  = '0;
    res_new  = '{reading_valid: 1'b0, verdict: VERDICT_OTHER, watts: '0, volts: '0};

    capturing_d       = capturing_q;
    closed_d          = closed_q;
    text_ended_d      = text_ended_q;
    chunk_count_d     = chunk_count_q;
    token_number_d    = token_number_q;
    token_chars_d     = token_chars_q;
    pend_ws_d         = pend_ws_q;
    command_char_d    = command_char_q;
    subcommand_char_d = subcommand_char_q;
    number_accum_d    = number_accum_q;
    number_done_d     = number_done_q;
    number_neg_d      = number_neg_q;
    tok_d             = tok_q;

    if (accept && !text_ended_q) begin
      if (c == CHR_NUL) begin
        text_ended_d = 1'b1;
      end else begin
        if (chunk_count_q != 2'd3) begin
          chunk_count_d = chunk_count_q + 2'd1;
        end
        if (c == CHR_HASH && !rx_i.chunk_end) begin
          capturing_d       = 1'b1;
          closed_d          = 1'b0;
          token_number_d    = '0;
          tok_d             = '0;
          command_char_d    = '0;
          subcommand_char_d = '0;
          token_chars_d     = 3'd1;
          pend_ws_d         = '0;
          number_accum_d    = '0;
          number_done_d     = 1'b1;
          number_neg_d      = 1'b0;
        end else if (capturing_q && !closed_q) begin
          if (c == CHR_SEMI) begin
            tok_d    = close_token(tok_q, token_number_q, token_chars_q, number_neg_q,
                                   sat_out(number_accum_q), |number_accum_q);
            closed_d = 1'b1;
          end else if (c == CHR_COMMA) begin
            tok_d = close_token(tok_q, token_number_q, token_chars_q, number_neg_q,
                                sat_out(number_accum_q), |number_accum_q);
            if (token_number_q != TOK_MAX) begin
              token_number_d = token_number_q + 5'd1;
            end
            token_chars_d  = '0;
            pend_ws_d      = '0;
            number_accum_d = '0;
            number_done_d  = 1'b0;
            number_neg_d   = 1'b0;
          end else if (ws) begin
            if (token_chars_q != 3'd0) begin
              if (pend_ws_q != 3'd7) begin
                pend_ws_d = pend_ws_q + 3'd1;
              end
              number_done_d = 1'b1;
            end
          end else begin
            if (token_number_q == TOK_CMD && pos == 4'd1) begin
              command_char_d = c;
            end
            if (token_number_q == TOK_SUB && pos == 4'd0) begin
              subcommand_char_d = c;
            end
            if (!number_done_q) begin
              if (c >= CHR_ZERO && c <= CHR_NINE) begin
                number_accum_d = (acc_x > {4'b0, {VB{1'b1}}}) ? '1 : acc_x[VB-1:0];
              end else if (pos == 4'd0 && (c == CHR_PLUS || c == CHR_MINUS)) begin
                number_neg_d = (c == CHR_MINUS);
              end else begin
                number_done_d = 1'b1;
              end
            end
            token_chars_d = (pos >= 4'd7) ? 3'd7 : 3'(pos + 4'd1);
            pend_ws_d     = '0;
          end
        end
      end
    end

    if (res_push) begin
      tok_end = tok_d;
      if (capturing_d && !closed_d) begin
        tok_end = close_token(tok_d, token_number_d, token_chars_d, number_neg_d,
                              sat_out(number_accum_d), |number_accum_d);
      end
      tn_less = token_number_d - 5'd2;
      priority if (chunk_count_d != 2'd3) begin
        res_new.verdict = VERDICT_OTHER;
      end else if (!capturing_d) begin
        res_new.verdict = VERDICT_NO_START;
      end else if (token_number_d < TOK_LEN) begin
        res_new.verdict = VERDICT_FEW_TOKENS;
      end else if (!tok_end.cmd_ok) begin
        res_new.verdict = VERDICT_BAD_CMD;
      end else if (!tok_end.sub_ok) begin
        res_new.verdict = VERDICT_BAD_SUB;
      end else if (!tok_end.len_present) begin
        res_new.verdict = VERDICT_NO_LENGTH;
      end else if (token_number_d == TOK_MAX || tok_end.declared != OUT_W'(tn_less)) begin
        res_new.verdict = VERDICT_MISMATCH;
      end else begin
        res_new.verdict       = VERDICT_OK;
        res_new.reading_valid = (command_char_d == CHR_CMD_D)
                                && (subcommand_char_d == CHR_MINUS)
                                && (tn_less == FieldCountW);
      end
      if (res_new.reading_valid) begin
        res_new.watts = tok_end.watts;
        res_new.volts = tok_end.volts;
      end

      capturing_d       = 1'b0;
      closed_d          = 1'b0;
      text_ended_d      = 1'b0;
      chunk_count_d     = '0;
      token_number_d    = '0;
      token_chars_d     = '0;
      pend_ws_d         = '0;
      command_char_d    = '0;
      subcommand_char_d = '0;
      number_accum_d    = '0;
      number_done_d     = 1'b0;
      number_neg_d      = 1'b0;
      tok_d             = '0;
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_pop) begin
      out_valid_d = 1'b0;
    end
    if (skid_valid_q && out_pop) begin
      out_d        = skid_q;
      out_valid_d  = 1'b1;
      skid_valid_d = 1'b0;
    end else if (res_push && (!out_valid_q || out_pop)) begin
      out_d       = res_new;
      out_valid_d = 1'b1;
    end else if (res_push) begin
      skid_d       = res_new;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capturing_q       <= 1'b0;
      closed_q          <= 1'b0;
      text_ended_q      <= 1'b0;
      chunk_count_q     <= '0;
      token_number_q    <= '0;
      token_chars_q     <= '0;
      pend_ws_q         <= '0;
      command_char_q    <= '0;
      subcommand_char_q <= '0;
      number_accum_q    <= '0;
      number_done_q     <= 1'b0;
      number_neg_q      <= 1'b0;
      tok_q             <= '0;
      out_valid_q       <= 1'b0;
      skid_valid_q      <= 1'b0;
    end else begin
      capturing_q       <= capturing_d;
      closed_q          <= closed_d;
      text_ended_q      <= text_ended_d;
      chunk_count_q     <= chunk_count_d;
      token_number_q    <= token_number_d;
      token_chars_q     <= token_chars_d;
      pend_ws_q         <= pend_ws_d;
      command_char_q    <= command_char_d;
      subcommand_char_q <= subcommand_char_d;
      number_accum_q    <= number_accum_d;
      number_done_q     <= number_done_d;
      number_neg_q      <= number_neg_d;
      tok_q             <= tok_d;
      out_valid_q       <= out_valid_d;
      skid_valid_q      <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.reading_valid = out_q.reading_valid;
  assign res_o.verdict       = out_q.verdict;
  assign res_o.watts_tenths  = out_q.watts;
  assign res_o.volts_tenths  = out_q.volts;

  `PMP_ASSERT_SAME(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q,
                   "Skid register holds a result while the output register is empty.")
  `PMP_ASSERT_NEXT(a_no_spurious_result, clk_i, rst_ni, !out_valid_q && !res_push,
                   !out_valid_q, "A result appeared without an accepted chunk end.")
  `PMP_ASSERT_NEXT(a_clear_after_chunk, clk_i, rst_ni, res_push,
                   !capturing_q && chunk_count_q == 2'd0 && token_number_q == 5'd0,
                   "Parser state was not cleared after a chunk end.")
  `PMP_ASSERT_SAME(a_reading_is_ok, clk_i, rst_ni, out_valid_q && out_q.reading_valid,
                   out_q.verdict == VERDICT_OK, "A reading was reported with a failing verdict.")

endmodule

// ----- dv/tb_power_meter_packet_parser.sv -----
// ----------------------------------------------------------------------------
// Power meter packet parser testbench
// Sends read chunks byte by byte and checks every chunk verdict against a
// cycle-free model of the parser. Directed chunks cover each verdict and the
// corner cases of the packet syntax. Random chunks follow, mostly well-formed
// packets with random fields, with random gaps and stalls and a long receiver
// hold-off that fills the result registers.
// ----------------------------------------------------------------------------
module tb_power_meter_packet_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import pmp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam longint unsigned ACCUM_MAX  = (64'd1 << PMP_VALUE_BITS) - 64'd1;
  localparam longint unsigned FIELD_MAX  = (64'd1 << OUT_W) - 64'd1;

  typedef struct packed {
    logic             reading_valid;
    verdict_e         verdict;
    logic [OUT_W-1:0] watts;
    logic [OUT_W-1:0] volts;
  } chunk_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pmp_byte_if   rx_if ();
  pmp_result_if res_if ();

  power_meter_packet_parser u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the parser state.
  logic                   sh_capturing, sh_closed, sh_text_ended;
  logic                   sh_cmd_ok, sh_sub_ok, sh_len_present;
  logic                   sh_num_done, sh_num_neg;
  logic [1:0]             sh_chunk_cnt;
  logic [4:0]             sh_tok_num;
  logic [2:0]             sh_tok_chars, sh_pend_ws;
  logic [7:0]             sh_cmd_char, sh_sub_char;
  logic [OUT_W-1:0]       sh_declared, sh_watts, sh_volts;
  longint unsigned        sh_accum;

  chunk_result_t pending_results[$];
  logic [7:0]    chunk_bytes[$];

  int  error_count = 0;
  int  bytes_sent = 0;
  int  chunks_sent = 0;
  int  readings_passed = 0;
  int  results_checked = 0;
  logic [7:0] verdicts_seen = '0;
  bit  calm_send = 1'b0;
  bit  calm_recv = 1'b0;
  int  hold_request = 0;

  function automatic bit is_space(input logic [7:0] c);
    return c == CHR_SPACE || (c >= CHR_TAB && c <= CHR_CR);
  endfunction

  function automatic logic [OUT_W-1:0] sat_field(input longint unsigned v);
    return (v > FIELD_MAX) ? '1 : v[OUT_W-1:0];
  endfunction

  function automatic void token_open();
    sh_tok_chars = '0;
    sh_pend_ws   = '0;
    sh_accum     = 0;
    sh_num_done  = 1'b0;
    sh_num_neg   = 1'b0;
  endfunction

  function automatic void shadow_clear();
    sh_capturing   = 1'b0;
    sh_closed      = 1'b0;
    sh_text_ended  = 1'b0;
    sh_cmd_ok      = 1'b0;
    sh_sub_ok      = 1'b0;
    sh_len_present = 1'b0;
    sh_chunk_cnt   = '0;
    sh_tok_num     = '0;
    sh_cmd_char    = '0;
    sh_sub_char    = '0;
    sh_declared    = '0;
    sh_watts       = '0;
    sh_volts       = '0;
    token_open();
  endfunction

  function automatic void token_close();
    case (sh_tok_num)
      TOK_CMD:   sh_cmd_ok = (sh_tok_chars == 3'd2);
      TOK_SUB:   sh_sub_ok = (sh_tok_chars == 3'd1);
      TOK_LEN: begin
        sh_len_present = (sh_tok_chars != 3'd0);
        sh_declared    = (sh_num_neg && sh_accum != 0) ? '1 : sat_field(sh_accum);
      end
      TOK_WATTS: sh_watts = sh_num_neg ? '0 : sat_field(sh_accum);
      TOK_VOLTS: sh_volts = sh_num_neg ? '0 : sat_field(sh_accum);
      default: ;
    endcase
  endfunction

  function automatic void token_take(input logic [7:0] c);
    int pos;
    if (is_space(c)) begin
      if (sh_tok_chars != 3'd0) begin
        if (sh_pend_ws < 3'd7) sh_pend_ws = sh_pend_ws + 3'd1;
        sh_num_done = 1'b1;
      end
      return;
    end
    pos = int'(sh_tok_chars) + int'(sh_pend_ws);
    if (sh_tok_num == TOK_CMD && pos == 1) sh_cmd_char = c;
    if (sh_tok_num == TOK_SUB && pos == 0) sh_sub_char = c;
    if (!sh_num_done) begin
      if (c >= CHR_ZERO && c <= CHR_NINE) begin
        sh_accum = sh_accum * 64'd10 + longint'(c - CHR_ZERO);
        if (sh_accum > ACCUM_MAX) sh_accum = ACCUM_MAX;
      end else if (pos == 0 && (c == CHR_PLUS || c == CHR_MINUS)) begin
        sh_num_neg = (c == CHR_MINUS);
      end else begin
        sh_num_done = 1'b1;
      end
    end
    sh_tok_chars = (pos + 1 > 7) ? 3'd7 : 3'(pos + 1);
    sh_pend_ws   = '0;
  endfunction

  function automatic void packet_open();
    sh_capturing   = 1'b1;
    sh_closed      = 1'b0;
    sh_tok_num     = '0;
    sh_cmd_ok      = 1'b0;
    sh_sub_ok      = 1'b0;
    sh_len_present = 1'b0;
    sh_declared    = '0;
    sh_watts       = '0;
    sh_volts       = '0;
    sh_cmd_char    = '0;
    sh_sub_char    = '0;
    token_open();
    token_take(CHR_HASH);
  endfunction

  // Advances the shadow parser by one byte and queues the verdict on chunk end.
  function automatic void parse_byte(input logic [7:0] c, input logic last);
    chunk_result_t r;
    int ntok;
    if (!sh_text_ended) begin
      if (c == CHR_NUL) begin
        sh_text_ended = 1'b1;
      end else begin
        if (sh_chunk_cnt < 2'd3) sh_chunk_cnt = sh_chunk_cnt + 2'd1;
        if (c == CHR_HASH && !last) begin
          packet_open();
        end else if (sh_capturing && !sh_closed) begin
          if (c == CHR_SEMI) begin
            token_close();
            sh_closed = 1'b1;
          end else if (c == CHR_COMMA) begin
            token_close();
            if (sh_tok_num < TOK_MAX) sh_tok_num = sh_tok_num + 5'd1;
            token_open();
          end else begin
            token_take(c);
          end
        end
      end
    end
    if (!last) return;
    if (sh_capturing && !sh_closed) token_close();
    ntok = int'(sh_tok_num) + 1;
    r = '0;
    if (sh_chunk_cnt < 2'd3) r.verdict = VERDICT_OTHER;
    else if (!sh_capturing) r.verdict = VERDICT_NO_START;
    else if (ntok < 3) r.verdict = VERDICT_FEW_TOKENS;
    else if (!sh_cmd_ok) r.verdict = VERDICT_BAD_CMD;
    else if (!sh_sub_ok) r.verdict = VERDICT_BAD_SUB;
    else if (!sh_len_present) r.verdict = VERDICT_NO_LENGTH;
    else if (sh_tok_num >= TOK_MAX || int'(sh_declared) != ntok - 3)
      r.verdict = VERDICT_MISMATCH;
    else begin
      r.verdict = VERDICT_OK;
      r.reading_valid = (sh_cmd_char == CHR_CMD_D && sh_sub_char == CHR_MINUS &&
                         ntok - 3 == int'(PMP_FIELD_COUNT));
    end
    if (r.reading_valid) begin
      r.watts = sh_watts;
      r.volts = sh_volts;
      readings_passed++;
    end
    verdicts_seen[r.verdict] = 1'b1;
    pending_results.push_back(r);
    shadow_clear();
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_error(input string what);
    error_count++;
    $display("[%0t] ERROR: %s", $realtime, what);
  endtask

  task automatic send_rx_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = calm_send ? 0 : idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      rx_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx_if.valid     = 1'b1;
    rx_if.rx_byte   = b;
    rx_if.chunk_end = last;
    do @(posedge clk_i); while (!rx_if.ready);
    parse_byte(b, last);
    bytes_sent++;
  endtask

  task automatic add_byte(input logic [7:0] b);
    chunk_bytes.push_back(b);
  endtask

  task automatic add_str(input string s);
    foreach (s[i]) chunk_bytes.push_back(s[i]);
  endtask

  task automatic send_chunk();
    foreach (chunk_bytes[i]) send_rx_byte(chunk_bytes[i], i == chunk_bytes.size() - 1);
    chunk_bytes.delete();
    chunks_sent++;
  endtask

  function automatic logic [7:0] pick_text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126));
    while (c == CHR_HASH || c == CHR_COMMA || c == CHR_SEMI);
    return c;
  endfunction

  task automatic add_number();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 8) add_byte(CHR_SPACE);
    if (r >= 90 && r < 95) add_byte(CHR_MINUS);
    else if (r >= 95) add_byte(CHR_PLUS);
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 4);
    repeat (n) add_byte(8'(CHR_ZERO + $urandom_range(0, 9)));
    if ($urandom_range(0, 15) == 0) add_str(".5");
    if ($urandom_range(0, 9) == 0) add_byte(CHR_TAB);
  endtask

  task automatic add_reading(input logic [7:0] cmd, input logic [7:0] sub, input int len,
                             input int fields);
    add_byte(CHR_HASH);
    add_byte(cmd);
    add_byte(CHR_COMMA);
    add_byte(sub);
    add_byte(CHR_COMMA);
    add_str($sformatf("%0d", len));
    repeat (fields) begin
      add_byte(CHR_COMMA);
      add_number();
    end
  endtask

  task automatic test_verdict_codes();
    add_str("ab");        send_chunk();
    add_str("xyz");       send_chunk();
    add_str("#d,-;");     send_chunk();
    add_str("#dd,-,0;");  send_chunk();
    add_str("#d,--,0;");  send_chunk();
    add_str("#d,-, ;");   send_chunk();
    add_str("#d,-,2,1;"); send_chunk();
    add_str("#x,y,0;");   send_chunk();
    add_str("#d,-,18,1234,2301");
    repeat (PMP_FIELD_COUNT - 2) add_str(",7");
    add_str(";");
    send_chunk();
  endtask

  task automatic test_special_cases();
    add_str(" # d , - , 1 , 5 ;\t"); send_chunk();
    add_str("#a,b,0;#d,-,0");        send_chunk();
    add_str("xyz#");                 send_chunk();
    add_str("#a,b,0#");              send_chunk();
    add_str("#a,b,0"); add_byte(CHR_NUL); add_str(",1,2"); send_chunk();
    add_str("ab#"); add_byte(CHR_NUL); add_str("zz");       send_chunk();
    add_str("#a,b,-0;");             send_chunk();
    add_str("#a,b,-1;");             send_chunk();
    add_str("#a,b,+2,x,y;");         send_chunk();
    add_str("#d,-,18,99999999, -5 ");
    repeat (PMP_FIELD_COUNT - 2) add_str(",1");
    add_str(";\r\n");
    send_chunk();
    add_str("#a,b,40");
    repeat (35) add_str(",");
    add_str(";");
    send_chunk();
    add_byte(CHR_NUL);               send_chunk();
    add_byte(8'hFF); add_byte(8'hFF); add_byte(8'hFF); send_chunk();
  endtask

  task automatic test_random_chunks();
    int start_bytes;
    int kind;
    int m;
    int fields;
    int len;
    int n;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < 260) begin
      calm_send = ($urandom_range(0, 4) == 0);
      calm_recv = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) add_byte(pick_text_char());
        if ($urandom_range(0, 5) == 0) add_str("#x,");
        m      = $urandom_range(0, 11);
        fields = PMP_FIELD_COUNT;
        len    = PMP_FIELD_COUNT;
        if (m == 0) len = ($urandom_range(0, 1) == 1) ? len + 1 : len - 1;
        if (m == 1) fields = fields - 1;
        add_reading((m == 2) ? pick_text_char() : CHR_CMD_D,
                    (m == 3) ? pick_text_char() : CHR_MINUS, len, fields);
        if (m != 4) add_byte(CHR_SEMI);
        if ($urandom_range(0, 2) == 0) add_str("\r\n");
      end else if (kind < 7) begin
        n = $urandom_range(0, 6);
        add_reading(pick_text_char(), pick_text_char(),
                    ($urandom_range(0, 7) == 0) ? n + 1 : n, n);
        add_byte(CHR_SEMI);
      end else begin
        repeat ($urandom_range(1, 20)) add_byte(8'($urandom_range(0, 255)));
      end
      send_chunk();
    end
    calm_send = 1'b0;
    calm_recv = 1'b0;
  endtask

  task automatic test_backpressure();
    calm_send    = 1'b1;
    hold_request = 300;
    repeat (40) begin
      add_str(($urandom_range(0, 1) == 1) ? "#q,r,0;" : "abc");
      send_chunk();
    end
    calm_send = 1'b0;
  endtask

  initial begin
    int stall_left;
    int hold_left;
    int g;
    stall_left   = 0;
    hold_left    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        res_if.ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        res_if.ready = 1'b0;
        stall_left--;
      end else if (calm_recv) begin
        res_if.ready = 1'b1;
      end else begin
        g = idle_len();
        if (g > 0) stall_left = g - 1;
        res_if.ready = (g == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    chunk_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_error("result item arrived with no chunk pending");
      end else begin
        want = pending_results.pop_front();
        if (res_if.reading_valid !== want.reading_valid)
          report_error($sformatf("reading_valid %b, want %b",
                                 res_if.reading_valid, want.reading_valid));
        if (res_if.verdict !== want.verdict)
          report_error($sformatf("verdict %0d, want %0d (%s)",
                                 res_if.verdict, want.verdict, want.verdict.name()));
        if (res_if.watts_tenths !== want.watts)
          report_error($sformatf("watts_tenths %0d, want %0d",
                                 res_if.watts_tenths, want.watts));
        if (res_if.volts_tenths !== want.volts)
          report_error($sformatf("volts_tenths %0d, want %0d",
                                 res_if.volts_tenths, want.volts));
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[%0t] ERROR: no item moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("power_meter_packet_parser verification failed");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    rx_if.valid     = 1'b0;
    rx_if.rx_byte   = '0;
    rx_if.chunk_end = 1'b0;
    shadow_clear();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_verdict_codes();
    test_special_cases();
    test_random_chunks();
    test_backpressure();

    @(negedge clk_i);
    rx_if.valid = 1'b0;
    calm_recv   = 1'b1;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0) report_error("chunk verdicts still pending at the end");

    $display("Sent %0d bytes in %0d chunks; %0d verdicts checked, %0d complete readings.",
             bytes_sent, chunks_sent, results_checked, readings_passed);
    $display("Verdict codes seen (bit per code, code 0 rightmost): %b", verdicts_seen);
    if (error_count == 0) begin
      $display("power_meter_packet_parser verification clean");
    end else begin
      $display("power_meter_packet_parser verification failed");
    end
    $finish;
  end

endmodule
